/* design/i2c_slave_packet_handler_defines.svh */
// ----------------------------------------------------------------------------
// I2C slave packet handler assertion macros
// Assertion wrappers for the engine, the design file that checks its own logic.
// ----------------------------------------------------------------------------
`ifndef I2C_SLAVE_PACKET_HANDLER_DEFINES_SVH
`define I2C_SLAVE_PACKET_HANDLER_DEFINES_SVH

// checked only while out of reset
`define I2CPH_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);

// checked at every edge, reset included
`define I2CPH_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/i2cph_pkg.sv */
// ----------------------------------------------------------------------------
// I2C slave packet handler package
// Widths, codes and the word types passed between the handler's parts.
// ----------------------------------------------------------------------------
package i2cph_pkg;

	localparam int RX_DEPTH_DEF = 32;
	localparam int TX_DEPTH_DEF = 32;
	localparam int OPQ_DEPTH    = 2;
	localparam int RESQ_DEPTH   = 4;
	localparam int RESQ_CW      = $clog2(RESQ_DEPTH + 1);

	localparam int DATA_W     = 8;
	localparam int ADDR_W     = 7;
	localparam int LIDX_W     = 5;
	localparam int LEN_W      = 6;
	localparam int KIND_W     = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;
	localparam int ERR_W      = 8;

	localparam logic [ERR_W-1:0] ERR_THR_RST = 8'd10;
	localparam logic [ERR_W-1:0] ERR_MAX     = 8'd255;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ERR_THR = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_TX = 1'b1;

	typedef enum logic [KIND_W-1:0] {
		KIND_NONE  = 3'd0,
		KIND_TX    = 3'd1,
		KIND_PKT   = 3'd2,
		KIND_EMPTY = 3'd3,
		KIND_RESET = 3'd4
	} res_kind_t;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_ADDR = 2'd1,
		OP_DATA = 2'd2
	} op_kind_t;

	typedef enum logic [1:0] {
		B_IDLE = 2'd0,
		B_TXRD = 2'd1,
		B_WALK = 2'd2
	} bk_state_t;

	// classified input word, front to back
	typedef struct packed {
		op_kind_t            kind;
		logic                stop;
		logic                ack;
		logic [DATA_W-1:0]   bus_byte;
		logic                load_ok;
		logic [LIDX_W-1:0]   load_index;
		logic [DATA_W-1:0]   load_value;
	} op_t;

	// result word
	typedef struct packed {
		res_kind_t           kind;
		logic [DATA_W-1:0]   data;
		logic [ADDR_W-1:0]   slave_address;
		logic [LEN_W-1:0]    packet_length;
		logic                last;
	} res_t;

endpackage

/* design/i2c_slave_packet_handler.sv */
// Order: a transmit byte passes the op queue, the engine's idle and fetch states and the result
// queue; empty-packet and reset-request words are made in idle, packet words in the walk state.
// Flow: loads and stored data words end in idle, words that send a byte add the fetch state (tx RAM
// registered read); a stop of n bytes streams n words, 1 per cycle while results have room.
// Reset: arst_n clears all control state and marks the transmit buffer as all zeros;
// no clearing pass, items are accepted right after reset.
// ----------------------------------------------------------------------------
// I2C slave packet handler
// Top level: configuration registers, front end, engine and result queue.
// ----------------------------------------------------------------------------
module i2c_slave_packet_handler #(
	parameter int RX_DEPTH = i2cph_pkg::RX_DEPTH_DEF,
	parameter int TX_DEPTH = i2cph_pkg::TX_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input word queue
	input  logic                              push,
	output logic                              full,
	input  logic                              cmd,
	input  logic                              is_address,
	input  logic                              stop_seen,
	input  logic                              master_ack,
	input  logic [i2cph_pkg::DATA_W-1:0]      bus_byte,
	input  logic [i2cph_pkg::LIDX_W-1:0]      load_index,
	input  logic [i2cph_pkg::DATA_W-1:0]      load_value,
	// result word queue
	output logic                              empty,
	input  logic                              pop,
	output logic [i2cph_pkg::KIND_W-1:0]      kind,
	output logic [i2cph_pkg::DATA_W-1:0]      data,
	output logic [i2cph_pkg::ADDR_W-1:0]      slave_address,
	output logic [i2cph_pkg::LEN_W-1:0]       packet_length,
	output logic                              last,
	// configuration writes
	input  logic                              wr_en,
	input  logic [i2cph_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [i2cph_pkg::CFG_DATA_W-1:0]  wr_data
);

	import i2cph_pkg::*;

	op_t                 op;
	logic                op_valid, op_pop;
	logic [ERR_W-1:0]    err_thr_q;
	logic                hold_tx_q;
	logic [RESQ_CW-1:0]  res_count, out_free;
	logic                res_push;
	res_t                res_in, res_out;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_thr_q <= ERR_THR_RST;
			hold_tx_q <= 1'b0;
		end else if (wr_en) begin
			case (wr_index)
				REG_ERR_THR: err_thr_q <= wr_data[ERR_W-1:0];
				REG_HOLD_TX: hold_tx_q <= wr_data[0];
				default: begin
				end
			endcase
		end
	end

	i2cph_front #(
		.TX_DEPTH (TX_DEPTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.cmd          (cmd),
		.is_address   (is_address),
		.stop_seen    (stop_seen),
		.master_ack   (master_ack),
		.bus_byte     (bus_byte),
		.load_index   (load_index),
		.load_value   (load_value),
		.op           (op),
		.op_valid     (op_valid),
		.op_pop       (op_pop)
	);

	i2cph_back #(
		.RX_DEPTH (RX_DEPTH),
		.TX_DEPTH (TX_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (op),
		.op_valid (op_valid),
		.op_pop   (op_pop),
		.err_thr  (err_thr_q),
		.hold_tx  (hold_tx_q),
		.out_free (out_free),
		.res_push (res_push),
		.res      (res_in)
	);

	// result queue
	assign out_free = RESQ_CW'(RESQ_DEPTH) - res_count;

	i2cph_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (RESQ_DEPTH)
	) u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res_in),
		.full   (),
		.pop    (pop),
		.dout   (res_out),
		.empty  (empty),
		.count  (res_count)
	);

	assign kind          = res_out.kind;
	assign data          = res_out.data;
	assign slave_address = res_out.slave_address;
	assign packet_length = res_out.packet_length;
	assign last          = res_out.last;

endmodule

/* design/i2cph_ram.sv */
// ----------------------------------------------------------------------------
// I2C slave packet handler RAM
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module i2cph_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* design/i2cph_fifo.sv */
// ----------------------------------------------------------------------------
// I2C slave packet handler FIFO
// Small flop-based queue with fill count, used for op and result words.
// ----------------------------------------------------------------------------
module i2cph_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic [WIDTH-1:0]               din,
	output logic                           full,
	input  logic                           pop,
	output logic [WIDTH-1:0]               dout,
	output logic                           empty,
	output logic [$clog2(DEPTH+1)-1:0]     count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign count   = cnt_q;
	assign dout    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

/* design/i2cph_front.sv */
// ----------------------------------------------------------------------------
// I2C slave packet handler front end
// Accepts input words, sorts them into load, address and data ops, queues them.
// ----------------------------------------------------------------------------
module i2cph_front #(
	parameter int TX_DEPTH = i2cph_pkg::TX_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic                            cmd,
	input  logic                            is_address,
	input  logic                            stop_seen,
	input  logic                            master_ack,
	input  logic [i2cph_pkg::DATA_W-1:0]    bus_byte,
	input  logic [i2cph_pkg::LIDX_W-1:0]    load_index,
	input  logic [i2cph_pkg::DATA_W-1:0]    load_value,
	output i2cph_pkg::op_t                  op,
	output logic                            op_valid,
	input  logic                            op_pop
);

	import i2cph_pkg::*;

	op_t  op_in;
	logic opq_empty;

	// classify the incoming word
	always_comb begin
		op_in            = '0;
		op_in.stop       = stop_seen;
		op_in.ack        = master_ack;
		op_in.bus_byte   = bus_byte;
		op_in.load_index = load_index;
		op_in.load_value = load_value;
		op_in.load_ok    = (32'(load_index) < 32'(TX_DEPTH));
		if (cmd) begin
			op_in.kind = OP_LOAD;
		end else if (is_address) begin
			op_in.kind = OP_ADDR;
		end else begin
			op_in.kind = OP_DATA;
		end
	end

	// op queue toward the engine
	i2cph_fifo #(
		.WIDTH ($bits(op_t)),
		.DEPTH (OPQ_DEPTH)
	) u_opq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (op_in),
		.full   (full),
		.pop    (op_pop),
		.dout   (op),
		.empty  (opq_empty),
		.count  ()
	);

	assign op_valid = !opq_empty;

endmodule

/* design/i2cph_back.sv */
// ----------------------------------------------------------------------------
// I2C slave packet handler engine
// Runs queued ops against transaction state and the tx/rx buffers, makes results.
// ----------------------------------------------------------------------------
`include "i2c_slave_packet_handler_defines.svh"

module i2cph_back #(
	parameter int RX_DEPTH = i2cph_pkg::RX_DEPTH_DEF,
	parameter int TX_DEPTH = i2cph_pkg::TX_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  i2cph_pkg::op_t                  op,
	input  logic                            op_valid,
	output logic                            op_pop,
	input  logic [i2cph_pkg::ERR_W-1:0]     err_thr,
	input  logic                            hold_tx,
	input  logic [i2cph_pkg::RESQ_CW-1:0]   out_free,
	output logic                            res_push,
	output i2cph_pkg::res_t                 res
);

	import i2cph_pkg::*;

	localparam int TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
	localparam int RX_AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
	localparam int TX_PW = $clog2(TX_DEPTH + 1);
	localparam int RX_PW = $clog2(RX_DEPTH + 1);
	localparam int LW    = (TX_AW > LIDX_W) ? TX_AW : LIDX_W;

	bk_state_t          st_q, st_d;
	logic [RX_PW-1:0]   rx_cnt_q, rx_cnt_d;
	logic [TX_PW-1:0]   tx_ptr_q, tx_ptr_d;
	logic [ADDR_W-1:0]  addr_q, addr_d;
	logic               rd_q, rd_d;
	logic               act_q, act_d;
	logic               apend_q, apend_d;
	logic [ERR_W-1:0]   err_q, err_d, err_inc;
	logic [TX_DEPTH-1:0] tx_vld_q, tx_vld_d;
	logic [RX_PW-1:0]   walk_idx_q, walk_idx_d;
	logic [RX_PW-1:0]   walk_n_q, walk_n_d;
	logic               pend_q, pend_d;
	logic               plast_q, plast_d;
	logic               txv_q, txv_d;

	logic               go, do_txrd;
	logic               tx_in_rng, rx_in_rng;
	logic [TX_AW-1:0]   tx_idx, tx_waddr;
	logic [LW-1:0]      lidx_w;
	logic               tx_we, tx_re, rx_we, rx_re;
	logic [DATA_W-1:0]  tx_rdata, rx_rdata;

	assign tx_in_rng = (tx_ptr_q < TX_PW'(TX_DEPTH));
	assign rx_in_rng = (rx_cnt_q < RX_PW'(RX_DEPTH));
	assign tx_idx    = tx_ptr_q[TX_AW-1:0];
	assign lidx_w    = LW'(op.load_index);
	assign tx_waddr  = lidx_w[TX_AW-1:0];
	assign go        = op_valid && (out_free != '0);
	assign err_inc   = (err_q == ERR_MAX) ? ERR_MAX : err_q + 1'b1;

	// next state and result generation
	always_comb begin
		st_d       = st_q;
		rx_cnt_d   = rx_cnt_q;
		tx_ptr_d   = tx_ptr_q;
		addr_d     = addr_q;
		rd_d       = rd_q;
		act_d      = act_q;
		apend_d    = apend_q;
		err_d      = err_q;
		tx_vld_d   = tx_vld_q;
		walk_idx_d = walk_idx_q;
		walk_n_d   = walk_n_q;
		pend_d     = 1'b0;
		plast_d    = plast_q;
		txv_d      = txv_q;
		op_pop     = 1'b0;
		do_txrd    = 1'b0;
		tx_we      = 1'b0;
		tx_re      = 1'b0;
		rx_we      = 1'b0;
		rx_re      = 1'b0;
		res_push   = 1'b0;
		res        = '0;
		res.kind   = KIND_NONE;

		case (st_q)
			B_IDLE: begin
				if (go) begin
					op_pop = 1'b1;
					case (op.kind)
						OP_LOAD: begin
							if (op.load_ok) begin
								tx_we              = 1'b1;
								tx_vld_d[tx_waddr] = 1'b1;
							end
						end
						OP_ADDR: begin
							if (apend_q && (err_inc > err_thr)) begin
								// too many address words in a row: reset request
								rx_cnt_d   = '0;
								tx_ptr_d   = '0;
								addr_d     = '0;
								rd_d       = 1'b0;
								act_d      = 1'b0;
								apend_d    = 1'b0;
								err_d      = '0;
								tx_vld_d   = '0;
								res_push   = 1'b1;
								res.kind   = KIND_RESET;
								res.last   = 1'b1;
							end else begin
								err_d   = apend_q ? err_inc : '0;
								apend_d = 1'b1;
								act_d   = 1'b1;
								addr_d  = op.bus_byte[DATA_W-1:1];
								rd_d    = op.bus_byte[0];
								do_txrd = op.bus_byte[0];
							end
						end
						OP_DATA: begin
							if (act_q) begin
								apend_d = 1'b0;
								if (rd_q) begin
									if (op.ack) begin
										do_txrd = 1'b1;
									end else begin
										// master nack ends the read
										tx_ptr_d = '0;
										act_d    = 1'b0;
										if (!hold_tx) begin
											tx_vld_d = '0;
										end
									end
								end else if (op.stop) begin
									act_d    = 1'b0;
									rx_cnt_d = '0;
									if (rx_cnt_q == '0) begin
										res_push          = 1'b1;
										res.kind          = KIND_EMPTY;
										res.slave_address = addr_q;
										res.last          = 1'b1;
									end else begin
										walk_n_d   = rx_cnt_q;
										walk_idx_d = '0;
										st_d       = B_WALK;
									end
								end else if (rx_in_rng) begin
									rx_we    = 1'b1;
									rx_cnt_d = rx_cnt_q + 1'b1;
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			B_TXRD: begin
				res_push          = 1'b1;
				res.kind          = KIND_TX;
				res.data          = txv_q ? tx_rdata : '0;
				res.slave_address = addr_q;
				res.last          = 1'b1;
				st_d              = B_IDLE;
			end
			B_WALK: begin
				// read ahead only when the result queue can take the word
				if (pend_q) begin
					res_push          = 1'b1;
					res.kind          = KIND_PKT;
					res.data          = rx_rdata;
					res.slave_address = addr_q;
					res.packet_length = LEN_W'(walk_n_q);
					res.last          = plast_q;
				end
				if ((walk_idx_q < walk_n_q) && (out_free > RESQ_CW'(pend_q))) begin
					rx_re      = 1'b1;
					pend_d     = 1'b1;
					plast_d    = ((walk_idx_q + 1'b1) == walk_n_q);
					walk_idx_d = walk_idx_q + 1'b1;
				end else if ((walk_idx_q == walk_n_q) && !pend_q) begin
					st_d = B_IDLE;
				end
			end
			default: begin
				st_d = B_IDLE;
			end
		endcase

		// transmit byte fetch, shared by address-read and acked data
		if (do_txrd) begin
			tx_re = 1'b1;
			txv_d = tx_in_rng ? tx_vld_q[tx_idx] : 1'b0;
			if (tx_in_rng) begin
				tx_ptr_d = tx_ptr_q + 1'b1;
			end
			st_d = B_TXRD;
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= B_IDLE;
			rx_cnt_q   <= '0;
			tx_ptr_q   <= '0;
			addr_q     <= '0;
			rd_q       <= 1'b0;
			act_q      <= 1'b0;
			apend_q    <= 1'b0;
			err_q      <= '0;
			tx_vld_q   <= '0;
			walk_idx_q <= '0;
			walk_n_q   <= '0;
			pend_q     <= 1'b0;
			plast_q    <= 1'b0;
			txv_q      <= 1'b0;
		end else begin
			st_q       <= st_d;
			rx_cnt_q   <= rx_cnt_d;
			tx_ptr_q   <= tx_ptr_d;
			addr_q     <= addr_d;
			rd_q       <= rd_d;
			act_q      <= act_d;
			apend_q    <= apend_d;
			err_q      <= err_d;
			tx_vld_q   <= tx_vld_d;
			walk_idx_q <= walk_idx_d;
			walk_n_q   <= walk_n_d;
			pend_q     <= pend_d;
			plast_q    <= plast_d;
			txv_q      <= txv_d;
		end
	end

	// transmit buffer
	i2cph_ram #(
		.WIDTH (DATA_W),
		.DEPTH (TX_DEPTH)
	) u_tx_ram (
		.clk   (clk),
		.we    (tx_we),
		.waddr (tx_waddr),
		.wdata (op.load_value),
		.re    (tx_re),
		.raddr (tx_idx),
		.rdata (tx_rdata)
	);

	// receive packet buffer
	i2cph_ram #(
		.WIDTH (DATA_W),
		.DEPTH (RX_DEPTH)
	) u_rx_ram (
		.clk   (clk),
		.we    (rx_we),
		.waddr (rx_cnt_q[RX_AW-1:0]),
		.wdata (op.bus_byte),
		.re    (rx_re),
		.raddr (walk_idx_q[RX_AW-1:0]),
		.rdata (rx_rdata)
	);

	`I2CPH_ASSERT(a_push_room, res_push |-> (out_free != '0), "result pushed into full queue")
	`I2CPH_ASSERT(a_txrd_one, (st_q == B_TXRD) |=> (st_q == B_IDLE), "tx fetch did not finish")
	`I2CPH_ASSERT(a_walk_bound, (st_q == B_WALK) |-> (walk_idx_q <= walk_n_q), "walk overran packet")
	`I2CPH_ASSERT(a_rx_bound, rx_cnt_q <= RX_PW'(RX_DEPTH), "rx count past depth")

endmodule

/* dv/i2c_slave_packet_handler_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C slave packet handler testbench
// Drives byte events and transmit buffer loads through the input queue and
// checks every result word against a cycle-free model of the handler. A short
// directed table comes first, then random transactions under four idling
// patterns and several register settings, with one long result hold-off.
// ----------------------------------------------------------------------------
module i2c_slave_packet_handler_test;
	import i2cph_pkg::*;

	localparam int LIMIT   = 300000;
	localparam int SPLIT_B = 16;     // table rows run with the reset settings

	// one input word, field by field
	typedef struct {
		bit                  cmd;
		bit                  is_addr;
		bit                  stop;
		bit                  ack;
		logic [DATA_W-1:0]   bus_byte;
		logic [LIDX_W-1:0]   lidx;
		logic [DATA_W-1:0]   lval;
	} in_word_t;

	// table row: word plus an optional typed-in result
	typedef struct {
		in_word_t  w;
		bit        typed;
		res_t      want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic cmd = 1'b0;
	logic is_address = 1'b0;
	logic stop_seen = 1'b0;
	logic master_ack = 1'b0;
	logic [DATA_W-1:0] bus_byte = '0;
	logic [LIDX_W-1:0] load_index = '0;
	logic [DATA_W-1:0] load_value = '0;
	logic empty;
	logic pop = 1'b0;
	logic [KIND_W-1:0] kind;
	logic [DATA_W-1:0] data;
	logic [ADDR_W-1:0] slave_address;
	logic [LEN_W-1:0] packet_length;
	logic last;
	logic wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] wr_index = '0;
	logic [CFG_DATA_W-1:0] wr_data = '0;

	i2c_slave_packet_handler DUT (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full),
		.cmd(cmd), .is_address(is_address), .stop_seen(stop_seen),
		.master_ack(master_ack), .bus_byte(bus_byte),
		.load_index(load_index), .load_value(load_value),
		.empty(empty), .pop(pop),
		.kind(kind), .data(data), .slave_address(slave_address),
		.packet_length(packet_length), .last(last),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// handler state as the model sees it
	logic [DATA_W-1:0] rx_mem [RX_DEPTH_DEF];
	logic [DATA_W-1:0] tx_mem [TX_DEPTH_DEF];
	int unsigned rx_fill;
	int unsigned tx_ptr;
	logic [ADDR_W-1:0] cur_addr;
	bit rd_op;
	bit txn_open;
	bit addr_seen;
	int unsigned err_run;
	logic [ERR_W-1:0] thr_reg = ERR_THR_RST;
	bit hold_reg = 1'b0;

	res_t step_words[$];   // words caused by the last input word
	res_t due_words[$];    // words still owed by the handler
	dir_row_t dir_rows[$];

	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int rx_hold_len = 0;
	int live_items = 0;
	int fail_count = 0;
	int tick_count = 0;

	function automatic void clear_model();
		foreach (tx_mem[i]) tx_mem[i] = '0;
		foreach (rx_mem[i]) rx_mem[i] = '0;
		rx_fill = 0;
		tx_ptr = 0;
		cur_addr = '0;
		rd_op = 1'b0;
		txn_open = 1'b0;
		addr_seen = 1'b0;
		err_run = 0;
	endfunction

	function automatic res_t make_res(res_kind_t k, logic [DATA_W-1:0] d,
			logic [ADDR_W-1:0] a, logic [LEN_W-1:0] len, logic lst);
		res_t r;
		r.kind = k;
		r.data = d;
		r.slave_address = a;
		r.packet_length = len;
		r.last = lst;
		return r;
	endfunction

	// next transmit byte; zero once the pointer has run off the end
	function automatic logic [DATA_W-1:0] next_tx_byte();
		logic [DATA_W-1:0] v;
		v = '0;
		if (tx_ptr < TX_DEPTH_DEF) begin
			v = tx_mem[tx_ptr];
			tx_ptr++;
		end
		return v;
	endfunction

	// Advance the handler model by one word, filling step_words.
	// Returns 0 when the word is ignored.
	function automatic bit handle_word(in_word_t w);
		int n;
		int i;
		step_words.delete();
		if (w.cmd) begin
			if (int'(w.lidx) < TX_DEPTH_DEF)
				tx_mem[w.lidx] = w.lval;
			return 1'b1;
		end
		if (w.is_addr) begin
			// back-to-back address bytes count toward a reset request
			if (addr_seen) begin
				if (err_run < 255)
					err_run++;
				if (err_run > thr_reg) begin
					clear_model();
					step_words.push_back(make_res(KIND_RESET, '0, '0, '0, 1'b1));
					return 1'b1;
				end
			end else begin
				err_run = 0;
			end
			addr_seen = 1'b1;
			txn_open = 1'b1;
			cur_addr = w.bus_byte[7:1];
			rd_op = w.bus_byte[0];
			if (rd_op)
				step_words.push_back(make_res(KIND_TX, next_tx_byte(), cur_addr, '0, 1'b1));
			return 1'b1;
		end
		if (!txn_open)
			return 1'b0;
		addr_seen = 1'b0;
		// read: ack sends the next byte, nack ends the read
		if (rd_op) begin
			if (w.ack) begin
				step_words.push_back(make_res(KIND_TX, next_tx_byte(), cur_addr, '0, 1'b1));
			end else begin
				tx_ptr = 0;
				txn_open = 1'b0;
				if (!hold_reg)
					foreach (tx_mem[j]) tx_mem[j] = '0;
			end
			return 1'b1;
		end
		// write with stop: stream the stored packet
		if (w.stop) begin
			n = rx_fill;
			txn_open = 1'b0;
			rx_fill = 0;
			if (n == 0) begin
				step_words.push_back(make_res(KIND_EMPTY, '0, cur_addr, '0, 1'b1));
			end else begin
				for (i = 0; i < n && i < RX_DEPTH_DEF; i++)
					step_words.push_back(make_res(KIND_PKT, rx_mem[i], cur_addr,
						LEN_W'(n), (i + 1 == n)));
			end
			return 1'b1;
		end
		if (rx_fill < RX_DEPTH_DEF) begin
			rx_mem[rx_fill] = w.bus_byte;
			rx_fill++;
		end
		return 1'b1;
	endfunction

	function automatic in_word_t bus_word(bit ia, bit st, bit ak, logic [DATA_W-1:0] b);
		in_word_t w;
		w.cmd = 1'b0;
		w.is_addr = ia;
		w.stop = st;
		w.ack = ak;
		w.bus_byte = b;
		w.lidx = LIDX_W'($urandom);
		w.lval = DATA_W'($urandom);
		return w;
	endfunction

	function automatic in_word_t load_word(logic [LIDX_W-1:0] idx, logic [DATA_W-1:0] val);
		in_word_t w;
		w.cmd = 1'b1;
		w.is_addr = $urandom_range(1);
		w.stop = $urandom_range(1);
		w.ack = $urandom_range(1);
		w.bus_byte = DATA_W'($urandom);
		w.lidx = idx;
		w.lval = val;
		return w;
	endfunction

	function automatic void add_row(in_word_t w, bit typed, res_t want);
		dir_row_t r;
		r.w = w;
		r.typed = typed;
		r.want = want;
		dir_rows.push_back(r);
	endfunction

	function automatic void note_fail(string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s", $realtime, msg);
	endfunction

	// compare the popped word with the oldest owed word
	function automatic void check_result();
		res_t w;
		if (due_words.size() == 0) begin
			note_fail($sformatf("unexpected word: kind %0d data %02h addr %02h len %0d last %0d",
				kind, data, slave_address, packet_length, last));
			return;
		end
		w = due_words.pop_front();
		if (kind !== w.kind || data !== w.data || slave_address !== w.slave_address ||
				packet_length !== w.packet_length || last !== w.last)
			note_fail($sformatf({"mismatch (exp/act): kind %0d/%0d data %02h/%02h ",
				"addr %02h/%02h len %0d/%0d last %0d/%0d"},
				w.kind, kind, w.data, data, w.slave_address, slave_address,
				w.packet_length, packet_length, w.last, last));
	endfunction

	// offer one word until taken, then book what it owes
	task automatic send_word(in_word_t w, bit typed = 1'b0, res_t want = '0);
		while ($urandom_range(99) < tx_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		cmd <= w.cmd;
		is_address <= w.is_addr;
		stop_seen <= w.stop;
		master_ack <= w.ack;
		bus_byte <= w.bus_byte;
		load_index <= w.lidx;
		load_value <= w.lval;
		do @(posedge clk); while (full);
		if (handle_word(w))
			live_items++;
		if (typed)
			due_words.push_back(want);
		else
			foreach (step_words[i]) due_words.push_back(step_words[i]);
	endtask

	task automatic await_results();
		push <= 1'b0;
		while (due_words.size() != 0)
			@(posedge clk);
	endtask

	// idle long enough for words that owe nothing to clear the engine
	task automatic settle_idle();
		await_results();
		repeat (40) @(posedge clk);
	endtask

	task automatic write_regs(logic [ERR_W-1:0] thr, bit hold);
		wr_en <= 1'b1;
		wr_index <= REG_ERR_THR;
		wr_data <= thr;
		@(posedge clk);
		wr_index <= REG_HOLD_TX;
		wr_data <= {7'($urandom), hold};
		@(posedge clk);
		wr_en <= 1'b0;
		thr_reg = thr;
		hold_reg = hold;
	endtask

	task automatic random_loads(int cnt);
		repeat (cnt) send_word(load_word(LIDX_W'($urandom), DATA_W'($urandom)));
	endtask

	// write transaction: address, n data bytes, then stop unless broken off
	task automatic write_txn(int n, bit finish);
		send_word(bus_word(1'b1, $urandom_range(1), $urandom_range(1),
			{7'($urandom), 1'b0}));
		repeat (n) begin
			if ($urandom_range(15) == 0)
				random_loads(1);
			send_word(bus_word(1'b0, 1'b0, $urandom_range(1), DATA_W'($urandom)));
		end
		if (finish)
			send_word(bus_word(1'b0, 1'b1, $urandom_range(1), DATA_W'($urandom)));
	endtask

	// read transaction: address, k acked bytes, then nack unless broken off
	task automatic read_txn(int k, bit finish);
		send_word(bus_word(1'b1, $urandom_range(1), $urandom_range(1),
			{7'($urandom), 1'b1}));
		repeat (k)
			send_word(bus_word(1'b0, $urandom_range(1), 1'b1, DATA_W'($urandom)));
		if (finish)
			send_word(bus_word(1'b0, $urandom_range(1), 1'b0, DATA_W'($urandom)));
	endtask

	task automatic addr_burst(int r);
		repeat (r)
			send_word(bus_word(1'b1, $urandom_range(1), $urandom_range(1),
				DATA_W'($urandom)));
	endtask

	task automatic noise_word();
		in_word_t w;
		w.cmd = $urandom_range(1);
		w.is_addr = $urandom_range(1);
		w.stop = $urandom_range(1);
		w.ack = $urandom_range(1);
		w.bus_byte = DATA_W'($urandom);
		w.lidx = LIDX_W'($urandom);
		w.lval = DATA_W'($urandom);
		send_word(w);
	endtask

	// mostly well-formed transactions with random content
	task automatic run_traffic(int target);
		int stop_at;
		int pick;
		int n;
		stop_at = live_items + target;
		while (live_items < stop_at) begin
			pick = $urandom_range(99);
			n = ($urandom_range(9) == 0) ? $urandom_range(30, 34) : $urandom_range(0, 8);
			if (pick < 40)
				write_txn(n, $urandom_range(9) != 0);
			else if (pick < 70)
				read_txn(n, $urandom_range(9) != 0);
			else if (pick < 85)
				random_loads($urandom_range(1, 4));
			else if (pick < 95)
				addr_burst($urandom_range(1, (thr_reg > 10) ? 12 : thr_reg + 2));
			else
				noise_word();
		end
	endtask

	// result side: check popped words, then pick pop for the next edge
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop && !empty)
				check_result();
			if (rx_hold_len > 0) begin
				rx_hold_len--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		tick_count <= tick_count + 1;
		if (tick_count >= LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// stimulus
	initial begin
		clear_model();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: threshold 10, no hold
		add_row(bus_word(1'b1, 1'b0, 1'b0, 8'hA3), 1'b1,
			make_res(KIND_TX, 8'h00, 7'h51, '0, 1'b1));
		add_row(bus_word(1'b0, 1'b0, 1'b1, 8'h12), 1'b0, '0);
		add_row(bus_word(1'b0, 1'b0, 1'b0, 8'h34), 1'b0, '0);
		add_row(load_word(5'd0, 8'hFF), 1'b0, '0);
		add_row(load_word(5'd31, 8'h00), 1'b0, '0);
		add_row(load_word(5'd1, 8'h5A), 1'b0, '0);
		add_row(bus_word(1'b1, 1'b0, 1'b0, 8'hFF), 1'b1,
			make_res(KIND_TX, 8'hFF, 7'h7F, '0, 1'b1));
		add_row(bus_word(1'b0, 1'b1, 1'b1, 8'h00), 1'b0, '0);
		add_row(bus_word(1'b0, 1'b0, 1'b0, 8'h00), 1'b0, '0);
		add_row(bus_word(1'b1, 1'b0, 1'b0, 8'h00), 1'b0, '0);
		add_row(bus_word(1'b0, 1'b1, 1'b1, 8'hFF), 1'b1,
			make_res(KIND_EMPTY, 8'h00, 7'h00, '0, 1'b1));
		add_row(bus_word(1'b0, 1'b0, 1'b0, 8'hAA), 1'b0, '0);
		add_row(bus_word(1'b1, 1'b0, 1'b0, 8'hFE), 1'b0, '0);
		add_row(bus_word(1'b0, 1'b0, 1'b0, 8'hFF), 1'b0, '0);
		add_row(bus_word(1'b0, 1'b0, 1'b1, 8'h00), 1'b0, '0);
		add_row(bus_word(1'b0, 1'b1, 1'b0, 8'h55), 1'b0, '0);
		// threshold 0, hold on: second address raises a reset request
		add_row(load_word(5'd0, 8'h81), 1'b0, '0);
		add_row(bus_word(1'b1, 1'b0, 1'b0, 8'h41), 1'b1,
			make_res(KIND_TX, 8'h81, 7'h20, '0, 1'b1));
		add_row(bus_word(1'b1, 1'b0, 1'b0, 8'h40), 1'b1,
			make_res(KIND_RESET, 8'h00, 7'h00, '0, 1'b1));
		add_row(load_word(5'd0, 8'h3C), 1'b0, '0);
		add_row(bus_word(1'b1, 1'b0, 1'b0, 8'h05), 1'b0, '0);
		add_row(bus_word(1'b0, 1'b0, 1'b0, 8'h00), 1'b0, '0);
		add_row(bus_word(1'b1, 1'b0, 1'b0, 8'h07), 1'b0, '0);
		add_row(bus_word(1'b0, 1'b0, 1'b0, 8'h00), 1'b0, '0);

		foreach (dir_rows[i]) begin
			if (i == SPLIT_B) begin
				settle_idle();
				write_regs(8'd0, 1'b1);
			end
			send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].want);
		end

		// no idling; reads and writes past the buffer ends
		settle_idle();
		write_regs(ERR_THR_RST, 1'b0);
		random_loads(4);
		read_txn(34, 1'b1);
		write_txn(34, 1'b1);
		run_traffic(60);

		// sender mostly idle; top threshold under a long run of address words
		settle_idle();
		tx_idle_pct = 83;
		write_regs(ERR_MAX, 1'b1);
		addr_burst(24);
		send_word(bus_word(1'b0, 1'b0, 1'b0, DATA_W'($urandom)));
		run_traffic(60);

		// receiver mostly stalled; long hold-off fills the block
		settle_idle();
		tx_idle_pct = 0;
		rx_stall_pct = 83;
		write_regs(8'd3, 1'b0);
		rx_hold_len = 400;
		write_txn(35, 1'b1);
		read_txn(3, 1'b1);
		random_loads(3);
		await_results();
		run_traffic(60);

		// both sides idle now and then
		settle_idle();
		tx_idle_pct = 26;
		rx_stall_pct = 26;
		write_regs(ERR_W'($urandom_range(1, 6)), $urandom_range(1));
		run_traffic(60);

		// drain and let any late word show up
		await_results();
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

/* files.f */
+incdir+design
design/i2cph_pkg.sv
design/i2cph_ram.sv
design/i2cph_fifo.sv
design/i2cph_front.sv
design/i2cph_back.sv
design/i2c_slave_packet_handler.sv
dv/i2c_slave_packet_handler_test.sv
